[hdl/easing_curve_generator_top_assert.svh]
// assertion macros shared by the easing curve checker
`ifndef EASING_CURVE_GENERATOR_TOP_ASSERT_SVH
`define EASING_CURVE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ECG_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("easing curve check failed");

// next-cycle implication, checked outside reset
`define ECG_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("easing curve check failed");

`endif

[hdl/ecg_pkg.sv]
// shared types, constants and curve tables of the easing curve generator
package ecg_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int Q_W            = 17;
    localparam int RAD_W          = 34;
    localparam int ROOT_W         = 17;
    localparam int REM_W          = 19;
    localparam int DL_DEPTH       = 13;
    localparam int ECG_LATENCY    = 40;
    localparam logic [4:0] SEL_LAST = 5'd21;

    localparam logic [Q_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [Q_W-1:0] HALF_Q16 = 17'h08000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURVE,
        CFG_START,
        CFG_END,
        CFG_TOTAL
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FAM_QUAD,
        FAM_CUBIC,
        FAM_QUART,
        FAM_QUINT,
        FAM_SINE,
        FAM_EXPO,
        FAM_CIRC,
        FAM_LINEAR
    } t_fam;

    typedef enum logic [1:0] {
        MODE_IN,
        MODE_OUT,
        MODE_INOUT
    } t_mode;

    typedef struct packed {
        logic valid;
        logic at_end;
    } t_ctl;

    // cosine over a quarter turn, q16
    localparam logic [Q_W-1:0] COS_TAB [17] = '{
        17'd65536, 17'd65220, 17'd64277, 17'd62714, 17'd60547, 17'd57798,
        17'd54491, 17'd50660, 17'd46341, 17'd41576, 17'd36410, 17'd30893,
        17'd25080, 17'd19024, 17'd12785, 17'd6424,  17'd0
    };

    // 2^(-k/16), q16
    localparam logic [Q_W-1:0] EXP_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

endpackage

[hdl/ecg_div.sv]
// pipelined restoring divider for progress = count * 2^16 / total
module ecg_div
    import ecg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [COUNT_BITS-1:0] i_cnt,
    input  logic [COUNT_BITS-1:0] i_tot,
    output t_ctl                  o_ctl,
    output logic [Q_W-1:0]        o_quo
);

    t_ctl                  r_ctl [Q_W];
    logic [COUNT_BITS-1:0] r_rem [Q_W];
    logic [Q_W-1:0]        r_quo [Q_W];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [COUNT_BITS:0] a;
        logic [COUNT_BITS:0] diff;
        logic [Q_W-1:0]      q_in;
        t_ctl                c_in;
        logic                ge;

        if (k == 0) begin : g_first
            assign a    = {1'b0, i_cnt};
            assign q_in = '0;
            assign c_in = i_ctl;
        end else begin : g_next
            assign a    = {r_rem[k-1], 1'b0};
            assign q_in = r_quo[k-1];
            assign c_in = r_ctl[k-1];
        end

        assign ge   = a >= {1'b0, i_tot};
        assign diff = a - {1'b0, i_tot};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[COUNT_BITS-1:0] : a[COUNT_BITS-1:0];
            r_quo[k] <= {q_in[Q_W-2:0], ge};
        end
    end

    assign o_ctl = r_ctl[Q_W-1];
    assign o_quo = r_quo[Q_W-1];

endmodule

[hdl/ecg_sqrt.sv]
// pipelined integer square root, one root bit per stage
module ecg_sqrt
    import ecg_pkg::*;
(
    input  logic              i_clk,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    // each stage brings down the next bit pair of the radicand
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  a;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign a     = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = a >= trial;

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
            r_rem[k]  <= ge ? (a - trial) : a;
            r_root[k] <= {root_in[ROOT_W-2:0], ge};
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

[hdl/easing_curve_generator_top.sv]
// top level of the easing curve generator: config registers and curve pipeline
//
// Usage: write curve_select, start_value, end_value and frame_total through the
// config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) while no
// item is in flight. Then raise start with i_frame_count; the item is taken
// at each rising edge with start high and busy low. One item can be taken
// every cycle. o_valid marks each result for one cycle, with o_eased_value
// and o_at_end. Their path runs through the input stage, the 17-stage progress
// divider, the 17-stage square root of the circ curve and the final multiply,
// rounding and saturation stages to the output registers.
// All curves share one path length, so results leave in input order.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets the registers
// to linear, 0, 0 and 1 frame, and holds busy high and o_cfg_ready low while
// active; busy stays high for the first cycle after release.
// The receiver cannot stall; results are never held back or repeated.
module easing_curve_generator_top
    import ecg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COUNT_BITS-1:0]        i_frame_count,
    output logic                         o_valid,
    output logic signed [VALUE_BITS-1:0] o_eased_value,
    output logic                         o_at_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int VB = VALUE_BITS;
    localparam int CB = COUNT_BITS;

    typedef struct packed {
        t_ctl           ctl;
        logic           circ;
        t_mode          mode;
        logic           half;
        logic [Q_W-1:0] fin;
    } t_dl;

    // config registers
    logic [4:0]           r_curve;
    logic signed [VB-1:0] r_start;
    logic signed [VB-1:0] r_end;
    logic [CB-1:0]        r_total;
    logic                 r_busy;
    logic [CB-1:0]        tot_eff;
    logic                 accept;

    assign o_cfg_ready = i_rst_n;
    assign busy        = r_busy | ~i_rst_n;
    assign accept      = start & ~busy;
    assign tot_eff     = (r_total == '0) ? CB'(1) : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_total <= CB'(1);
            r_busy  <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CURVE: r_curve <= i_cfg_data[4:0];
                    CFG_START: r_start <= i_cfg_data[VB-1:0];
                    CFG_END:   r_end   <= i_cfg_data[VB-1:0];
                    CFG_TOTAL: r_total <= i_cfg_data[CB-1:0];
                    default: ;
                endcase
            end
        end
    end

    // input stage: clamp count, flag end
    t_ctl          r_in_ctl;
    logic [CB-1:0] r_in_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else begin
            r_in_ctl.valid  <= accept;
            r_in_ctl.at_end <= i_frame_count >= tot_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_cnt <= (i_frame_count > tot_eff) ? tot_eff : i_frame_count;
    end

    // progress divider
    t_ctl           div_ctl;
    logic [Q_W-1:0] div_p;

    ecg_div #(
        .COUNT_BITS(CB)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_in_ctl),
        .i_cnt  (r_in_cnt),
        .i_tot  (tot_eff),
        .o_ctl  (div_ctl),
        .o_quo  (div_p)
    );

    // stage 0: decode curve, fold progress into the in-curve argument
    logic [4:0]     sel_m1;
    logic [7:0]     sel_mul;
    logic [2:0]     fam_raw;
    logic [4:0]     mode_raw;
    logic           linear;
    t_fam           fam_c;
    t_mode          mode_c;
    logic           half_c;
    logic [Q_W-1:0] p_neg;
    logic [Q_W-1:0] x_c;

    assign sel_m1   = r_curve - 5'd1;
    assign sel_mul  = {3'b000, sel_m1} * 8'd11;
    assign fam_raw  = sel_mul[7:5];
    assign mode_raw = sel_m1 - {1'b0, fam_raw, 1'b0} - {2'b00, fam_raw};
    assign linear   = (r_curve == 5'd0) || (r_curve > SEL_LAST);
    assign fam_c    = linear ? FAM_LINEAR : t_fam'(fam_raw);
    assign mode_c   = linear ? MODE_IN : t_mode'(mode_raw[1:0]);
    assign half_c   = div_p >= HALF_Q16;
    assign p_neg    = ONE_Q16 - div_p;

    always_comb begin
        case (mode_c)
            MODE_IN:    x_c = div_p;
            MODE_OUT:   x_c = p_neg;
            MODE_INOUT: x_c = half_c ? {p_neg[Q_W-2:0], 1'b0} : {div_p[Q_W-2:0], 1'b0};
            default:    x_c = div_p;
        endcase
    end

    t_ctl           r0_ctl;
    t_fam           r0_fam;
    t_mode          r0_mode;
    logic           r0_half;
    logic [Q_W-1:0] r0_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else begin
            r0_ctl <= div_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_fam  <= fam_c;
        r0_mode <= mode_c;
        r0_half <= half_c;
        r0_x    <= x_c;
    end

    // stage 1: square, sine table, expo exponent
    logic [Q_W-1:0] x_neg;
    logic [3:0]     s_idx;
    logic [Q_W-1:0] s_c0;
    logic [12:0]    s_dif;

    assign x_neg = ONE_Q16 - r0_x;
    assign s_idx = r0_x[15:12];

    always_comb begin
        if (r0_x[16]) begin
            s_c0  = COS_TAB[16];
            s_dif = '0;
        end else begin
            s_c0  = COS_TAB[{1'b0, s_idx}];
            s_dif = 13'(COS_TAB[{1'b0, s_idx}] - COS_TAB[{1'b0, s_idx} + 5'd1]);
        end
    end

    t_ctl           r1_ctl;
    t_fam           r1_fam;
    t_mode          r1_mode;
    logic           r1_half;
    logic [Q_W-1:0] r1_x;
    logic [33:0]    r1_xx;
    logic [Q_W-1:0] r1_sc0;
    logic [12:0]    r1_sdif;
    logic [11:0]    r1_sfr;
    logic [19:0]    r1_e;
    logic           r1_xz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= r0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_fam  <= r0_fam;
        r1_mode <= r0_mode;
        r1_half <= r0_half;
        r1_x    <= r0_x;
        r1_xx   <= r0_x * r0_x;
        r1_sc0  <= s_c0;
        r1_sdif <= s_dif;
        r1_sfr  <= r0_x[11:0];
        r1_e    <= {x_neg, 3'b000} + {2'b00, x_neg, 1'b0};
        r1_xz   <= r0_x == '0;
    end

    // radicand for the circ curve: 2^32 - x^2
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;

    assign rad = {2'b01, 32'h0} - r1_xx;

    ecg_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_rad (rad),
        .o_root(root)
    );

    // stage 2: power chain, sine product, expo table
    logic [33:0]    rnd1;
    logic [3:0]     e_idx;

    assign rnd1  = r1_xx + 34'd32768;
    assign e_idx = r1_e[15:12];

    t_ctl           r2_ctl;
    t_fam           r2_fam;
    t_mode          r2_mode;
    logic           r2_half;
    logic [Q_W-1:0] r2_x;
    logic [33:0]    r2_pw;
    logic [Q_W-1:0] r2_sc0;
    logic [24:0]    r2_sprod;
    logic [Q_W-1:0] r2_ec0;
    logic [11:0]    r2_edif;
    logic [11:0]    r2_efr;
    logic [3:0]     r2_en;
    logic           r2_xz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_fam   <= r1_fam;
        r2_mode  <= r1_mode;
        r2_half  <= r1_half;
        r2_x     <= r1_x;
        r2_pw    <= (r1_fam >= FAM_CUBIC) ? rnd1[32:16] * r1_x : {1'b0, rnd1[32:16], 16'h0};
        r2_sc0   <= r1_sc0;
        r2_sprod <= r1_sdif * r1_sfr;
        r2_ec0   <= EXP_TAB[{1'b0, e_idx}];
        r2_edif  <= 12'(EXP_TAB[{1'b0, e_idx}] - EXP_TAB[{1'b0, e_idx} + 5'd1]);
        r2_efr   <= r1_e[11:0];
        r2_en    <= r1_e[19:16];
        r2_xz    <= r1_xz;
    end

    // stage 3: power chain, sine value, expo product
    logic [33:0] rnd2;
    logic [25:0] s_rnd;
    logic [Q_W-1:0] s_val;

    assign rnd2  = r2_pw + 34'd32768;
    assign s_rnd = {1'b0, r2_sprod} + 26'd2048;
    assign s_val = r2_sc0 - {3'b000, s_rnd[25:12]};

    t_ctl           r3_ctl;
    t_fam           r3_fam;
    t_mode          r3_mode;
    logic           r3_half;
    logic [Q_W-1:0] r3_x;
    logic [33:0]    r3_pw;
    logic [Q_W-1:0] r3_sin;
    logic [Q_W-1:0] r3_ec0;
    logic [23:0]    r3_eprod;
    logic [3:0]     r3_en;
    logic           r3_xz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_fam   <= r2_fam;
        r3_mode  <= r2_mode;
        r3_half  <= r2_half;
        r3_x     <= r2_x;
        r3_pw    <= (r2_fam >= FAM_QUART) ? rnd2[32:16] * r2_x : {1'b0, rnd2[32:16], 16'h0};
        r3_sin   <= ONE_Q16 - s_val;
        r3_ec0   <= r2_ec0;
        r3_eprod <= r2_edif * r2_efr;
        r3_en    <= r2_en;
        r3_xz    <= r2_xz;
    end

    // stage 4: last power product, expo interpolation
    logic [33:0] rnd3;
    logic [24:0] e_rnd;

    assign rnd3  = r3_pw + 34'd32768;
    assign e_rnd = {1'b0, r3_eprod} + 25'd2048;

    t_ctl           r4_ctl;
    t_fam           r4_fam;
    t_mode          r4_mode;
    logic           r4_half;
    logic [Q_W-1:0] r4_x;
    logic [33:0]    r4_pw;
    logic [Q_W-1:0] r4_sin;
    logic [Q_W-1:0] r4_ev;
    logic [3:0]     r4_en;
    logic           r4_xz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_fam  <= r3_fam;
        r4_mode <= r3_mode;
        r4_half <= r3_half;
        r4_x    <= r3_x;
        r4_pw   <= (r3_fam >= FAM_QUINT) ? rnd3[32:16] * r3_x : {1'b0, rnd3[32:16], 16'h0};
        r4_sin  <= r3_sin;
        r4_ev   <= r3_ec0 - {4'h0, e_rnd[24:12]};
        r4_en   <= r3_en;
        r4_xz   <= r3_xz;
    end

    // stage 5: pick the in-curve value of the family
    logic [33:0]    rnd4;
    logic [17:0]    e_sum;
    logic [17:0]    e_shr;
    logic [Q_W-1:0] expo_c;
    logic [Q_W-1:0] fin_c;

    assign rnd4   = r4_pw + 34'd32768;
    assign e_sum  = {1'b0, r4_ev} + ((18'd1 << r4_en) >> 1);
    assign e_shr  = e_sum >> r4_en;
    assign expo_c = r4_xz ? '0 : e_shr[Q_W-1:0];

    always_comb begin
        case (r4_fam)
            FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: fin_c = rnd4[32:16];
            FAM_SINE:   fin_c = r4_sin;
            FAM_EXPO:   fin_c = expo_c;
            FAM_LINEAR: fin_c = r4_x;
            default:    fin_c = '0;
        endcase
    end

    t_dl r5;
    t_dl r_dl [DL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5.ctl <= '0;
        end else begin
            r5.ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r5.circ <= r4_fam == FAM_CIRC;
        r5.mode <= r4_mode;
        r5.half <= r4_half;
        r5.fin  <= fin_c;
    end

    // delay line that waits for the square root
    for (genvar k = 0; k < DL_DEPTH; k++) begin : g_dl
        t_dl d_in;

        if (k == 0) begin : g_first
            assign d_in = r5;
        end else begin : g_next
            assign d_in = r_dl[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl[k].ctl <= '0;
            end else begin
                r_dl[k].ctl <= d_in.ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dl[k].circ <= d_in.circ;
            r_dl[k].mode <= d_in.mode;
            r_dl[k].half <= d_in.half;
            r_dl[k].fin  <= d_in.fin;
        end
    end

    // stage 19: circ value and out / in-out folding
    t_dl            dl_last;
    logic [Q_W-1:0] fi;
    logic [Q_W:0]   fi_inc;
    logic [Q_W-1:0] f_c;

    assign dl_last = r_dl[DL_DEPTH-1];
    assign fi      = dl_last.circ ? (ONE_Q16 - root) : dl_last.fin;
    assign fi_inc  = {1'b0, fi} + 18'd1;

    always_comb begin
        case (dl_last.mode)
            MODE_IN:    f_c = fi;
            MODE_OUT:   f_c = ONE_Q16 - fi;
            MODE_INOUT: f_c = dl_last.half ? (ONE_Q16 - fi_inc[Q_W:1]) : fi_inc[Q_W:1];
            default:    f_c = fi;
        endcase
    end

    t_ctl           r19_ctl;
    logic [Q_W-1:0] r19_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r19_ctl <= '0;
        end else begin
            r19_ctl <= dl_last.ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r19_f <= f_c;
    end

    // stage 20: delta times factor
    logic signed [VB:0]    delta;
    logic signed [VB+18:0] prod_c;

    assign delta  = {r_end[VB-1], r_end} - {r_start[VB-1], r_start};
    assign prod_c = delta * $signed({1'b0, r19_f});

    t_ctl                  r20_ctl;
    logic signed [VB+18:0] r20_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r20_ctl <= '0;
        end else begin
            r20_ctl <= r19_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r20_prod <= prod_c;
    end

    // stage 21: round half away from zero, add start, saturate
    localparam logic signed [VB+2:0] Y_MAX = {4'b0000, {(VB-1){1'b1}}};
    localparam logic signed [VB+2:0] Y_MIN = {4'b1111, {(VB-1){1'b0}}};

    logic                  neg;
    logic [VB+18:0]        mag;
    logic [VB+18:0]        mag_rnd;
    logic signed [VB+2:0]  q;
    logic signed [VB+2:0]  y;
    logic signed [VB-1:0]  y_sat;

    assign neg     = r20_prod[VB+18];
    assign mag     = neg ? (-r20_prod) : r20_prod;
    assign mag_rnd = mag + (VB+19)'(32768);
    assign q       = neg ? -$signed(mag_rnd[VB+18:16]) : $signed(mag_rnd[VB+18:16]);
    assign y       = {{3{r_start[VB-1]}}, r_start} + q;

    always_comb begin
        if (y > Y_MAX) begin
            y_sat = Y_MAX[VB-1:0];
        end else if (y < Y_MIN) begin
            y_sat = Y_MIN[VB-1:0];
        end else begin
            y_sat = y[VB-1:0];
        end
    end

    logic                 r_out_v;
    logic signed [VB-1:0] r_out_val;
    logic                 r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r20_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= y_sat;
        r_out_end <= r20_ctl.at_end;
    end

    assign o_valid       = r_out_v;
    assign o_eased_value = r_out_val;
    assign o_at_end      = r_out_end;

endmodule

[hdl/ecg_checker.sv]
// port-level checker for the easing curve generator, bound to the top level
`include "easing_curve_generator_top_assert.svh"

module ecg_checker
    import ecg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COUNT_BITS-1:0] i_frame_count,
    input logic                  o_valid,
    input logic                  o_at_end
);

    // every result comes from an item taken a fixed latency earlier
    `ECG_ASSERT_IMP(a_result_has_item, o_valid, $past(start && !busy, ECG_LATENCY))

    // a count of zero can never be at the end
    `ECG_ASSERT_IMP(a_end_not_at_zero, o_valid && o_at_end, $past(i_frame_count, ECG_LATENCY) != '0)

    // once out of reset the block keeps taking items
    `ECG_ASSERT_NXT(a_busy_stays_low, !busy, !busy)

endmodule

bind easing_curve_generator_top ecg_checker #(
    .COUNT_BITS(COUNT_BITS)
) u_ecg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_frame_count(i_frame_count),
    .o_valid      (o_valid),
    .o_at_end     (o_at_end)
);
